// File: rtl/core/nas_pkg.sv
package nas_pkg;

    // table size
    localparam int MAX_AGENTS = 256;
    localparam int AGENT_AW   = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    // wide enough for an 8-bit index and any table index, used for range checks
    localparam int CMP_W      = 13;

    // field widths
    localparam int IDX_W      = 8;
    localparam int POS_W      = 24;
    localparam int TEAM_W     = 8;
    localparam int CODE_W     = 16;
    localparam int PNUM_W     = 16;
    localparam int MODE_W     = 4;
    localparam int RADIUS_W   = 16;

    // squarer and distance widths
    localparam int MUL_W      = POS_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIST_W     = PROD_W + 1;
    localparam int RAD_SHIFT  = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IDX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENEMY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NPC      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNPOST = 3'd5;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 16'd50000;
    localparam logic [CODE_W-1:0]   ENEMY_RESET    = 16'h0300;
    localparam logic [CODE_W-1:0]   NPC_RESET      = 16'h0600;
    localparam logic [CODE_W-1:0]   ITEM_RESET     = 16'h0400;
    localparam logic [CODE_W-1:0]   SIGNPOST_RESET = 16'h0200;

    // request types
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // search modes
    localparam logic [MODE_W-1:0] MODE_ANY       = 4'd0;
    localparam logic [MODE_W-1:0] MODE_OTHER_TEAM = 4'd1;
    localparam logic [MODE_W-1:0] MODE_ENEMY     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_LIVE_ENEMY = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ITEM      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SIGNPOST  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_NPC       = 4'd6;
    localparam logic [MODE_W-1:0] MODE_PLAYER    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_NEAR_ANY  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_NEAR_NPC  = 4'd9;

    typedef struct packed {
        logic [TEAM_W-1:0] team_id;
        logic [CODE_W-1:0] allegiance;
        logic [CODE_W-1:0] agent_kind;
        logic              alive;
        logic [PNUM_W-1:0] player_number;
    } agent_attr_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } agent_pos_t;

endpackage

// File: rtl/core/nas_ram.sv
module nas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/nearest_agent_search_top.sv
// Nearest agent search. The block holds a table of MAX_AGENTS agent records
// (presence, Q20.4 position, team, allegiance, kind, alive flag, player
// number). A write transaction (req_type 0) stores one record and produces
// no result. A search transaction (req_type 1) scans entries 1 to
// MAX_AGENTS-1, filters them by search_mode, and returns the entry with the
// smallest squared distance strictly below the squared search radius; ties
// go to the lower index, and index 0 with found 0 means no match. Timing:
// in_ready is high only while the block is idle. A search reads the entries
// in turn through a single 25x25 squarer shared by the radius, dx and dy; a
// search that fails early (unused mode, or an absent or out-of-range
// reference in modes 0-7) skips the scan and goes straight to the result.
// Records live in two single-port-write RAMs with registered reads; the
// presence bits are flops cleared by reset, so no clearing pass is needed.
// A finished result waits in an output register while new writes are
// accepted. Configuration must be written through cfg_wr_en/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce
// this. Indexes past the last register are ignored.
module nearest_agent_search_top import nas_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [IDX_W-1:0]           agent_index,
    input  logic                       present,
    input  logic signed [POS_W-1:0]    pos_x,
    input  logic signed [POS_W-1:0]    pos_y,
    input  logic [TEAM_W-1:0]          team_id,
    input  logic [CODE_W-1:0]          allegiance,
    input  logic [CODE_W-1:0]          agent_kind,
    input  logic                       alive,
    input  logic [PNUM_W-1:0]          player_number,
    input  logic [MODE_W-1:0]          search_mode,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [IDX_W-1:0]           nearest_index,
    output logic                       found
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REF  = 3'd1;   // read reference record, square radius
    localparam logic [2:0] S_INIT = 3'd2;   // latch reference, load best distance
    localparam logic [2:0] S_DX   = 3'd3;   // entry data in, square dx, settle previous
    localparam logic [2:0] S_DY   = 3'd4;   // square dy, fetch next entry
    localparam logic [2:0] S_LAST = 3'd5;   // settle last entry
    localparam logic [2:0] S_OUT  = 3'd6;   // hand result to output register

    localparam logic [AGENT_AW-1:0] LAST_IDX  = AGENT_AW'(MAX_AGENTS - 1);
    localparam logic [AGENT_AW-1:0] FIRST_IDX = AGENT_AW'(1);

    logic [2:0]                state_reg, state_next;

    // configuration registers
    logic [RADIUS_W-1:0]       radius_reg;
    logic [IDX_W-1:0]          own_idx_reg;
    logic [CODE_W-1:0]         enemy_code_reg;
    logic [CODE_W-1:0]         npc_code_reg;
    logic [CODE_W-1:0]         item_code_reg;
    logic [CODE_W-1:0]         signpost_code_reg;

    // presence bits, cleared at reset
    logic [MAX_AGENTS-1:0]     pres_reg;

    // search context
    logic [MODE_W-1:0]         mode_reg;
    logic [AGENT_AW-1:0]       ref_idx_reg;
    logic signed [POS_W-1:0]   qx_reg, qy_reg;
    logic [PNUM_W-1:0]         pnum_reg;
    logic signed [POS_W-1:0]   refx_reg, refy_reg;
    logic [TEAM_W-1:0]         ref_team_reg;

    // scan datapath
    logic [AGENT_AW-1:0]       i_reg;
    logic [DIST_W-1:0]         best_reg;
    logic [AGENT_AW-1:0]       best_idx_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         dx2_reg;
    logic [MUL_W-1:0]          dy_abs_reg;
    logic                      cand_ok_reg;
    logic                      cand_vld_reg;
    logic [AGENT_AW-1:0]       cand_idx_reg;

    // output register
    logic                      out_valid_reg;
    logic [IDX_W-1:0]          out_index_reg;
    logic                      out_found_reg;

    // RAM ports
    logic                      wr_en;
    logic [AGENT_AW-1:0]       wr_addr;
    logic [AGENT_AW-1:0]       rd_addr;
    agent_attr_t               attr_wr, attr_rd;
    agent_pos_t                pos_wr, pos_rd;

    // misc combinational
    logic                      in_fire;
    logic                      out_load;
    logic                      use_coords;
    logic [IDX_W-1:0]          ref_sel;
    logic [AGENT_AW-1:0]       ref_addr;
    logic                      ref_bad;
    logic                      early_fail;
    logic [MUL_W-1:0]          mul_op;
    logic [PROD_W-1:0]         prod_next;
    logic signed [POS_W:0]     dx_s, dy_s;
    logic [MUL_W-1:0]          dx_abs, dy_abs;
    logic                      filter_ok;
    logic [DIST_W-1:0]         cand_dist;
    logic                      settle;
    logic                      take;
    logic [CMP_W-1:0]          best_ext;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign out_valid     = out_valid_reg;
    assign nearest_index = out_index_reg;
    assign found         = out_found_reg;

    // record write: out-of-range indexes dropped
    assign wr_en   = in_fire && (req_type == REQ_WRITE)
                     && (CMP_W'(agent_index) < CMP_W'(MAX_AGENTS));
    assign wr_addr = AGENT_AW'(agent_index);

    assign attr_wr.team_id       = team_id;
    assign attr_wr.allegiance    = allegiance;
    assign attr_wr.agent_kind    = agent_kind;
    assign attr_wr.alive         = alive;
    assign attr_wr.player_number = player_number;
    assign pos_wr.x              = pos_x;
    assign pos_wr.y              = pos_y;

    nas_ram #(
        .WIDTH ($bits(agent_attr_t)),
        .DEPTH (MAX_AGENTS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (attr_wr),
        .raddr (rd_addr),
        .rdata (attr_rd)
    );

    nas_ram #(
        .WIDTH ($bits(agent_pos_t)),
        .DEPTH (MAX_AGENTS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (pos_wr),
        .raddr (rd_addr),
        .rdata (pos_rd)
    );

    // reference selection at acceptance
    assign ref_sel  = (search_mode == MODE_PLAYER) ? own_idx_reg : agent_index;
    assign ref_addr = AGENT_AW'(ref_sel);
    assign ref_bad  = (CMP_W'(ref_sel) >= CMP_W'(MAX_AGENTS)) || !pres_reg[ref_addr];
    assign early_fail = (search_mode > MODE_NEAR_NPC)
                        || ((search_mode < MODE_NEAR_ANY) && ref_bad);

    always_comb
    begin
        use_coords = 1'b0;
        if (mode_reg inside {[MODE_NEAR_ANY:MODE_NEAR_NPC]})
        begin
            use_coords = 1'b1;
        end
    end

    // per-entry differences against the reference point
    assign dx_s   = {pos_rd.x[POS_W-1], pos_rd.x} - {refx_reg[POS_W-1], refx_reg};
    assign dy_s   = {pos_rd.y[POS_W-1], pos_rd.y} - {refy_reg[POS_W-1], refy_reg};
    assign dx_abs = dx_s[POS_W] ? MUL_W'(-dx_s) : MUL_W'(dx_s);
    assign dy_abs = dy_s[POS_W] ? MUL_W'(-dy_s) : MUL_W'(dy_s);

    // mode filter on the entry being read
    always_comb
    begin
        case (mode_reg)
            MODE_ANY:        filter_ok = 1'b1;
            MODE_OTHER_TEAM: filter_ok = (attr_rd.team_id != ref_team_reg);
            MODE_ENEMY:      filter_ok = (attr_rd.allegiance == enemy_code_reg);
            MODE_LIVE_ENEMY: filter_ok = (attr_rd.allegiance == enemy_code_reg)
                                         && attr_rd.alive;
            MODE_ITEM:       filter_ok = (attr_rd.agent_kind == item_code_reg);
            MODE_SIGNPOST:   filter_ok = (attr_rd.agent_kind == signpost_code_reg);
            MODE_NPC:        filter_ok = (attr_rd.allegiance == npc_code_reg);
            MODE_PLAYER:     filter_ok = (attr_rd.agent_kind != signpost_code_reg)
                                         && (attr_rd.agent_kind != item_code_reg)
                                         && (attr_rd.player_number == pnum_reg);
            MODE_NEAR_ANY:   filter_ok = 1'b1;
            MODE_NEAR_NPC:   filter_ok = (attr_rd.allegiance == npc_code_reg);
            default:         filter_ok = 1'b0;
        endcase
    end

    // shared squarer operand
    always_comb
    begin
        case (state_reg)
            S_REF:   mul_op = MUL_W'(radius_reg);
            S_DX:    mul_op = dx_abs;
            S_DY:    mul_op = dy_abs_reg;
            default: mul_op = '0;
        endcase
    end
    assign prod_next = PROD_W'(mul_op) * PROD_W'(mul_op);

    // settle the pending candidate: dx^2 held, dy^2 in the product register
    assign cand_dist = DIST_W'(dx2_reg) + DIST_W'(prod_reg);
    assign settle    = (state_reg == S_DX) || (state_reg == S_LAST);
    assign take      = settle && cand_vld_reg && (cand_dist < best_reg)
                       && (use_coords || (cand_dist != '0));

    assign best_ext = CMP_W'(best_idx_reg);

    // RAM read address
    always_comb
    begin
        case (state_reg)
            S_REF:   rd_addr = ref_idx_reg;
            S_INIT:  rd_addr = FIRST_IDX;
            S_DY:    rd_addr = i_reg + FIRST_IDX;
            default: rd_addr = i_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (req_type == REQ_SEARCH))
                begin
                    state_next = early_fail ? S_OUT : S_REF;
                end
            end
            S_REF:  state_next = S_INIT;
            S_INIT: state_next = S_DX;
            S_DX:   state_next = S_DY;
            S_DY:   state_next = (i_reg == LAST_IDX) ? S_LAST : S_DX;
            S_LAST: state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            pres_reg          <= '0;
            out_valid_reg     <= 1'b0;
            cand_vld_reg      <= 1'b0;
            radius_reg        <= RADIUS_RESET;
            own_idx_reg       <= '0;
            enemy_code_reg    <= ENEMY_RESET;
            npc_code_reg      <= NPC_RESET;
            item_code_reg     <= ITEM_RESET;
            signpost_code_reg <= SIGNPOST_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
            begin
                pres_reg[wr_addr] <= present;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == S_INIT)
            begin
                cand_vld_reg <= 1'b0;
            end
            else if (state_reg == S_DY)
            begin
                cand_vld_reg <= cand_ok_reg;
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_RADIUS:   radius_reg        <= cfg_data;
                    CFG_OWN_IDX:  own_idx_reg       <= cfg_data[IDX_W-1:0];
                    CFG_ENEMY:    enemy_code_reg    <= cfg_data;
                    CFG_NPC:      npc_code_reg      <= cfg_data;
                    CFG_ITEM:     item_code_reg     <= cfg_data;
                    CFG_SIGNPOST: signpost_code_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;

        if (in_fire && (req_type == REQ_SEARCH))
        begin
            mode_reg     <= search_mode;
            ref_idx_reg  <= ref_addr;
            qx_reg       <= pos_x;
            qy_reg       <= pos_y;
            pnum_reg     <= player_number;
            best_idx_reg <= '0;
        end

        case (state_reg)
            S_INIT:
            begin
                refx_reg     <= use_coords ? qx_reg : pos_rd.x;
                refy_reg     <= use_coords ? qy_reg : pos_rd.y;
                ref_team_reg <= attr_rd.team_id;
                best_reg     <= DIST_W'(prod_reg) << RAD_SHIFT;
                i_reg        <= FIRST_IDX;
            end
            S_DX:
            begin
                dy_abs_reg  <= dy_abs;
                cand_ok_reg <= pres_reg[i_reg] && filter_ok;
            end
            S_DY:
            begin
                dx2_reg      <= prod_reg;
                cand_idx_reg <= i_reg;
                i_reg        <= i_reg + FIRST_IDX;
            end
            default: ;
        endcase

        if (take)
        begin
            best_reg     <= cand_dist;
            best_idx_reg <= cand_idx_reg;
        end

        if (out_load)
        begin
            out_index_reg <= best_ext[IDX_W-1:0];
            out_found_reg <= (best_idx_reg != '0);
        end
    end

    // the best distance only shrinks while scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DX || state_reg == S_DY) |=> (best_reg <= $past(best_reg)))
        else $error("best distance grew during scan");

    // entry 0 is never scanned
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DX) |-> (i_reg != '0))
        else $error("scan reached entry 0");

    // the last entry is settled right before the result is handed over
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAST) |=> (state_reg == S_OUT))
        else $error("scan did not end in result hand-off");

    // found matches a nonzero index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (found == (nearest_index != '0)))
        else $error("found flag disagrees with nearest_index");

endmodule
